// ===== sv/qfd_pkg.sv =====
// Package for the QoS flow description parser: item types, parser state and role codes.
package qfd_pkg;

   localparam logic [2:0] ROLE_QFI   = 3'd0;
   localparam logic [2:0] ROLE_OPC   = 3'd1;
   localparam logic [2:0] ROLE_CNT   = 3'd2;
   localparam logic [2:0] ROLE_PID   = 3'd3;
   localparam logic [2:0] ROLE_PLEN  = 3'd4;
   localparam logic [2:0] ROLE_UNIT  = 3'd5;
   localparam logic [2:0] ROLE_RATE  = 3'd6;
   localparam logic [2:0] ROLE_OTHER = 3'd7;

   localparam logic [7:0] RATE_ID_FIRST = 8'h02;
   localparam logic [7:0] RATE_ID_LAST  = 8'h05;
   localparam logic [7:0] FLOW_COUNT_MAX = 8'hff;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } qfd_req_type;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [15:0] field_value;
      logic        rate_complete;
      logic        ext_bit;
      logic [7:0]  flow_index;
      logic [5:0]  param_index;
      logic        truncated;
   } qfd_rsp_type;

   typedef struct packed {
      logic [2:0] parse_phase;
      logic [5:0] params_left;
      logic [7:0] content_left;
      logic [7:0] current_param_id;
      logic [1:0] rate_bytes_seen;
      logic [7:0] rate_high_byte;
      logic [7:0] flow_count;
      logic [5:0] param_count;
   } qfd_state_type;

   localparam qfd_state_type STATE_RESET = '{
      parse_phase:      ROLE_QFI,
      params_left:      6'd0,
      content_left:     8'd0,
      current_param_id: 8'd0,
      rate_bytes_seen:  2'd0,
      rate_high_byte:   8'd0,
      flow_count:       8'd1,
      param_count:      6'd0
   };

endpackage

// ===== sv/qfd_core.sv =====
// Per-byte decode: tags one byte and computes the parser's next state.
module qfd_core (
   input  qfd_pkg::qfd_state_type cur_state,
   input  qfd_pkg::qfd_req_type   req_item,
   output qfd_pkg::qfd_state_type nxt_state,
   output qfd_pkg::qfd_rsp_type   rsp_item
);
   import qfd_pkg::*;

   logic [7:0] b;
   logic       param_end;
   logic       flow_end;
   logic [5:0] params_dec;
   logic [7:0] content_dec;
   logic       is_rate;
   qfd_state_type st;

   assign b           = req_item.data_byte;
   assign content_dec = cur_state.content_left - 8'd1;
   assign is_rate     = (cur_state.current_param_id >= RATE_ID_FIRST) &&
                        (cur_state.current_param_id <= RATE_ID_LAST);

   always_comb begin
      st                     = cur_state;
      param_end              = 1'b0;
      flow_end               = 1'b0;
      params_dec             = 6'd0;
      rsp_item.byte_role     = cur_state.parse_phase;
      rsp_item.field_value   = {8'd0, b};
      rsp_item.rate_complete = 1'b0;
      rsp_item.ext_bit       = 1'b0;
      rsp_item.flow_index    = cur_state.flow_count;
      rsp_item.param_index   = 6'd0;
      rsp_item.truncated     = 1'b0;

      case (cur_state.parse_phase)
         ROLE_QFI: begin
            rsp_item.field_value = {10'd0, b[5:0]};
            st.parse_phase = ROLE_OPC;
         end
         ROLE_OPC: begin
            rsp_item.field_value = {13'd0, b[7:5]};
            st.parse_phase = ROLE_CNT;
         end
         ROLE_CNT: begin
            rsp_item.field_value = {10'd0, b[5:0]};
            rsp_item.ext_bit = b[6];
            st.params_left = b[5:0];
            st.param_count = 6'd0;
            if (b[5:0] == 6'd0) begin
               flow_end = 1'b1;
            end else begin
               st.parse_phase = ROLE_PID;
            end
         end
         ROLE_PID: begin
            st.current_param_id = b;
            st.param_count = cur_state.param_count + 6'd1;
            rsp_item.param_index = cur_state.param_count + 6'd1;
            st.parse_phase = ROLE_PLEN;
         end
         ROLE_PLEN: begin
            rsp_item.param_index = cur_state.param_count;
            st.content_left = b;
            if (b == 8'd0) begin
               param_end = 1'b1;
            end else if (is_rate) begin
               st.parse_phase = ROLE_UNIT;
            end else begin
               st.parse_phase = ROLE_OTHER;
            end
         end
         ROLE_UNIT: begin
            rsp_item.param_index = cur_state.param_count;
            st.rate_bytes_seen = 2'd0;
            st.content_left = content_dec;
            if (content_dec == 8'd0) begin
               param_end = 1'b1;
            end else begin
               st.parse_phase = ROLE_RATE;
            end
         end
         ROLE_RATE: begin
            rsp_item.param_index = cur_state.param_count;
            if (cur_state.rate_bytes_seen == 2'd0) begin
               st.rate_high_byte = b;
               st.rate_bytes_seen = 2'd1;
            end else if (cur_state.rate_bytes_seen == 2'd1) begin
               rsp_item.field_value = {cur_state.rate_high_byte, b};
               rsp_item.rate_complete = 1'b1;
               st.rate_bytes_seen = 2'd2;
            end else begin
               rsp_item.byte_role = ROLE_OTHER;
            end
            st.content_left = content_dec;
            if (content_dec == 8'd0) begin
               param_end = 1'b1;
            end
         end
         default: begin
            rsp_item.param_index = cur_state.param_count;
            st.content_left = content_dec;
            if (content_dec == 8'd0) begin
               param_end = 1'b1;
            end
         end
      endcase

      if (param_end) begin
         params_dec = st.params_left - 6'd1;
         st.content_left = 8'd0;
         st.params_left = params_dec;
         if (params_dec == 6'd0) begin
            flow_end = 1'b1;
         end else begin
            st.parse_phase = ROLE_PID;
         end
      end

      if (flow_end) begin
         if (cur_state.flow_count != FLOW_COUNT_MAX) begin
            st.flow_count = cur_state.flow_count + 8'd1;
         end
         st.param_count = 6'd0;
         st.params_left = 6'd0;
         st.parse_phase = ROLE_QFI;
      end

      if (req_item.last_byte) begin
         rsp_item.truncated = (st.parse_phase != ROLE_QFI);
         st = STATE_RESET;
      end

      nxt_state = st;
   end

endmodule

// ===== sv/qos_flow_description_parser.sv =====
// Top level of the QoS flow description parser: input register, decode and result register.
//
// Feed the content bytes of one QoS flow descriptions element on the req_ channel,
// one byte per item, with last_byte set on the final byte. Each byte yields one
// result item on the rsp_ channel carrying its role, the extracted field, the
// 16-bit rate on the second rate byte, and the flow and parameter indexes.
// An item moves when valid is high and stall is low.
// Path: an accepted byte waits in the input register, then its decode lands in
// the result register.
// Throughput: one byte per cycle while rsp_stall is low.
// When rsp_stall holds, the result register and the input register both hold;
// one more byte is taken into the empty input register, then req_stall rises.
// Reset clears both stages and returns the parser to expecting a flow
// identifier with the flow count at one. After each last byte the parser
// returns to that same state on its own.
module qos_flow_description_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qfd_pkg::qfd_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qfd_pkg::qfd_rsp_type rsp_item
);
   import qfd_pkg::*;

   logic          in_valid_ff;
   qfd_req_type   in_item_ff;
   logic          out_valid_ff;
   qfd_rsp_type   out_item_ff;
   qfd_state_type state_ff;
   qfd_state_type state_in;
   qfd_rsp_type   rsp_in;
   logic          advance;

   qfd_core u_core (
      .cur_state (state_ff),
      .req_item  (in_item_ff),
      .nxt_state (state_in),
      .rsp_item  (rsp_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
            in_item_ff  <= req_item;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            out_item_ff  <= rsp_in;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule
